[hdl/smf_pkg.sv]
// Shared types and constants of the sliding median filter.
`timescale 1ns / 1ps
package smf_pkg;

  localparam int MAX_TAPS     = 7;
  localparam int SAMPLE_WIDTH = 16;
  localparam int HALF_W       = $clog2(MAX_TAPS / 2 + 1);
  localparam int CNT_W        = HALF_W + 1;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0]  CFG_MEDIAN_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  CFG_MEDIAN_WINDOW = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET      = CFG_DATA_W'(3);
  localparam logic [CFG_DATA_W-1:0] MIN_TAPS          = CFG_DATA_W'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef sample_t [MAX_TAPS-1:0] win_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           frame_last;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           out_last;
  } out_res_t;

  typedef struct packed {
    sample_t           sample;
    logic              fill;
    logic              bypass;
    logic              last;
    logic              emit_first;
    logic [HALF_W-1:0] half;
    logic [HALF_W-1:0] pend;
  } cmd_t;

endpackage

[hdl/smf_front.sv]
// Front end: configuration registers, frame tracking and request classification.
`timescale 1ns / 1ps
module smf_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  smf_pkg::in_req_t                     in_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [smf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 q_ready,
  output logic                                 q_push,
  output smf_pkg::cmd_t                        q_cmd
);

  logic                              enable_r, enable_nxt;
  logic [smf_pkg::CFG_DATA_W-1:0]    window_r, window_nxt;
  logic                              start_r, start_nxt;
  logic [smf_pkg::HALF_W-1:0]        lag_r, lag_nxt;

  logic [smf_pkg::CFG_DATA_W-1:0]    wsel;
  logic [smf_pkg::CFG_DATA_W-1:0]    wodd;
  logic [smf_pkg::HALF_W-1:0]        half;
  logic [smf_pkg::HALF_W-1:0]        lag_cl;
  logic [smf_pkg::CNT_W-1:0]         pending;
  logic                              bypass;
  logic                              emit_first;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;
  assign q_push    = in_valid && q_ready;

  always_comb begin
    wsel = (window_r > smf_pkg::CFG_DATA_W'(smf_pkg::MAX_TAPS)) ?
           smf_pkg::CFG_DATA_W'(smf_pkg::MAX_TAPS) : window_r;
    wodd = wsel[0] ? wsel : wsel - smf_pkg::CFG_DATA_W'(1);
    half = smf_pkg::HALF_W'(wodd >> 1);
    bypass = !enable_r || (window_r < smf_pkg::MIN_TAPS);
    lag_cl = (lag_r > half) ? half : lag_r;
    pending = {1'b0, lag_cl} + smf_pkg::CNT_W'(1);
    emit_first = pending > {1'b0, half};
  end

  always_comb begin
    q_cmd.sample     = in_data.sample_in;
    q_cmd.fill       = start_r;
    q_cmd.bypass     = bypass;
    q_cmd.last       = in_data.frame_last;
    q_cmd.emit_first = emit_first;
    q_cmd.half       = half;
    q_cmd.pend       = emit_first ? half : pending[smf_pkg::HALF_W-1:0];
  end

  always_comb begin
    enable_nxt = enable_r;
    window_nxt = window_r;
    if (cfg_valid) begin
      priority if (cfg_index == smf_pkg::CFG_MEDIAN_ENABLE) begin
        enable_nxt = cfg_data[0];
      end else if (cfg_index == smf_pkg::CFG_MEDIAN_WINDOW) begin
        window_nxt = cfg_data;
      end else begin
        enable_nxt = enable_r;
      end
    end
  end

  always_comb begin
    start_nxt = start_r;
    lag_nxt   = lag_r;
    if (q_push) begin
      start_nxt = in_data.frame_last;
      lag_nxt   = (bypass || in_data.frame_last) ? '0 : q_cmd.pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      window_r <= smf_pkg::WINDOW_RESET;
      start_r  <= 1'b1;
      lag_r    <= '0;
    end else begin
      enable_r <= enable_nxt;
      window_r <= window_nxt;
      start_r  <= start_nxt;
      lag_r    <= lag_nxt;
    end
  end

endmodule

[hdl/smf_queue.sv]
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module smf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smf_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output smf_pkg::cmd_t pop_cmd
);

  smf_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hdl/smf_back.sv]
// Back end: window store, median network, flush sequencing and output register.
`timescale 1ns / 1ps
module smf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  smf_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output smf_pkg::out_res_t out_data
);

  function automatic smf_pkg::sample_t win_median(smf_pkg::win_t wv,
                                                  logic [smf_pkg::HALF_W-1:0] h);
    logic [smf_pkg::CNT_W-1:0] w;
    logic [smf_pkg::CNT_W-1:0] lt;
    logic [smf_pkg::CNT_W-1:0] le;
    logic                      found;
    smf_pkg::sample_t          r;
    w     = {h, 1'b1};
    r     = wv[0];
    found = 1'b0;
    for (int i = 0; i < smf_pkg::MAX_TAPS; i++) begin
      lt = '0;
      le = '0;
      for (int j = 0; j < smf_pkg::MAX_TAPS; j++) begin
        if (smf_pkg::CNT_W'(j) < w) begin
          if ($signed(wv[j]) < $signed(wv[i]))  lt = lt + smf_pkg::CNT_W'(1);
          if ($signed(wv[j]) <= $signed(wv[i])) le = le + smf_pkg::CNT_W'(1);
        end
      end
      if (!found && (smf_pkg::CNT_W'(i) < w) && (lt <= {1'b0, h}) && ({1'b0, h} < le)) begin
        r     = wv[i];
        found = 1'b1;
      end
    end
    return r;
  endfunction

  smf_pkg::win_t              store_r, store_nxt;
  logic [smf_pkg::HALF_W-1:0] step_r, step_nxt;
  logic                       out_valid_r, out_valid_nxt;
  smf_pkg::out_res_t          out_data_r, out_data_nxt;

  logic                       advance;
  logic                       first;
  logic                       done;
  logic                       emit;
  smf_pkg::sample_t           med;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign advance   = cmd_valid && (!out_valid_r || out_ready);
  assign first     = step_r == '0;
  assign cmd_pop   = advance && done;

  always_comb begin
    if (first && cmd.fill) begin
      for (int i = 0; i < smf_pkg::MAX_TAPS; i++) store_nxt[i] = cmd.sample;
    end else begin
      for (int i = smf_pkg::MAX_TAPS - 1; i > 0; i--) store_nxt[i] = store_r[i-1];
      store_nxt[0] = cmd.sample;
    end
    med = win_median(store_nxt, cmd.half);
  end

  always_comb begin
    done = first ? (cmd.bypass || !cmd.last) : (step_r == cmd.half);
    emit = first ? (cmd.bypass || cmd.emit_first) :
           (({1'b0, step_r} + {1'b0, cmd.pend}) > {1'b0, cmd.half});
    step_nxt = step_r;
    if (advance) begin
      step_nxt = done ? '0 : step_r + smf_pkg::HALF_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance && emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.sample_out = (first && cmd.bypass) ? cmd.sample : med;
      out_data_nxt.out_last   = first ? (cmd.bypass && cmd.last) : (step_r == cmd.half);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      store_r <= store_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/sliding_median_filter.sv]
// Top level of the sliding median filter: front end, command queue and back end.
// An accepted request passes through the command queue and then the output register.
// Throughput: one request per cycle unless the output stalls or the queue is full;
// the frame's last sample holds the back end while it shifts and emits the flush.
// Reset clears the queue, the sequencer, the output valid bit and the frame counters;
// median_enable returns to 0 and median_window to 3.
`timescale 1ns / 1ps
module sliding_median_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  smf_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output smf_pkg::out_res_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          q_ready;
  logic          q_push;
  smf_pkg::cmd_t q_cmd;
  logic          q_pop;
  logic          q_valid;
  smf_pkg::cmd_t q_head;

  smf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  smf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_head)
  );

  smf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
